// ===== rtl/core/fpst_pkg.sv =====
// Package for the Fenwick prefix-sum table: word types for the input and
// result channels, field widths, operation codes and the size register reset.
// No dependencies.
package fpst_pkg;

    localparam int POS_W  = 13;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 13;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] delta;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] prefix_sum;
        logic                     out_of_range;
    } t_out_word;

endpackage

// ===== rtl/core/fpst_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module fpst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/fenwick_prefix_sum_table.sv =====
// Top level of the Fenwick prefix-sum table: control sequencer around one RAM.
// Depends on fpst_pkg and fpst_ram.
//
// channel   direction  handshake               payload
// in        input      i_in_valid/o_in_ready   fpst_pkg::t_in_word
// out       output     o_out_valid/i_out_ready fpst_pkg::t_out_word
// cfg       input      i_cfg_valid/o_cfg_ready tree_size, 13 bits
//
// An add or query visits at most log2 of the size plus one tree entries; the single
// read port of the store sets the walk to one entry a cycle. A clear writes zero to
// all MAX_POSITIONS entries of the store. After reset the same clearing pass runs
// with o_in_ready low. A finished word waits in the output register while the
// next word is taken.
module fenwick_prefix_sum_table #(
    parameter int MAX_POSITIONS = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  fpst_pkg::t_in_word     i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output fpst_pkg::t_out_word    o_out_word,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [fpst_pkg::SIZE_W-1:0] i_cfg_data
);
    import fpst_pkg::*;

    localparam int AW = $clog2(MAX_POSITIONS);
    localparam int KW = ((AW > POS_W) ? AW : POS_W) + 2;
    localparam logic [KW-1:0] MAX_K     = KW'(MAX_POSITIONS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic                r_op_add, n_op_add;
    logic [KW-1:0]       r_k, n_k;
    logic [KW-1:0]       r_size, n_size;
    logic [DATA_W-1:0]   r_delta, n_delta;
    logic [DATA_W-1:0]   r_acc, n_acc;
    logic                r_flag, n_flag;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic                r_clr_emit, n_clr_emit;
    logic [SIZE_W-1:0]   r_tree_size, n_tree_size;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out_word, n_out_word;

    logic                in_accept;
    logic [KW-1:0]       size_k;
    logic [KW-1:0]       eff_size;
    logic [KW-1:0]       pos_k;
    logic [KW-1:0]       query_k;
    logic [KW-1:0]       k_low;
    logic [KW-1:0]       k_up;
    logic [KW-1:0]       k_down;
    logic [KW-1:0]       km1;
    logic [KW-1:0]       rd_k;
    logic [KW-1:0]       rd_km1;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [DATA_W-1:0]   rd_data;

    fpst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POSITIONS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign size_k    = {{(KW-SIZE_W){1'b0}}, r_tree_size};
    assign eff_size  = (size_k > MAX_K) ? MAX_K : size_k;
    assign pos_k     = {{(KW-POS_W){1'b0}}, i_in_word.position};
    assign query_k   = (pos_k > eff_size) ? eff_size : pos_k;
    assign k_low     = r_k & (~r_k + KW'(1));
    assign k_up      = r_k + k_low;
    assign k_down    = r_k - k_low;
    assign km1       = r_k - KW'(1);
    assign rd_km1    = rd_k - KW'(1);
    assign rd_addr   = rd_km1[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_op_add    = r_op_add;
        n_k         = r_k;
        n_size      = r_size;
        n_delta     = r_delta;
        n_acc       = r_acc;
        n_flag      = r_flag;
        n_clr_addr  = r_clr_addr;
        n_clr_emit  = r_clr_emit;
        n_tree_size = r_tree_size;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        rd_en       = 1'b0;
        rd_k        = r_k;
        wr_en       = 1'b0;
        wr_addr     = km1[AW-1:0];
        wr_data     = '0;

        if (i_cfg_valid) begin
            n_tree_size = i_cfg_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_emit ? ST_EMIT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_acc    = '0;
                    n_flag   = 1'b0;
                    n_delta  = i_in_word.delta;
                    n_size   = eff_size;
                    n_op_add = (i_in_word.opcode == OP_ADD);
                    case (i_in_word.opcode)
                        OP_ADD: begin
                            if (pos_k == '0 || pos_k > eff_size) begin
                                n_flag  = 1'b1;
                                n_state = ST_EMIT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_k    = pos_k;
                                n_k     = pos_k;
                                n_state = ST_WALK;
                            end
                        end
                        OP_QUERY: begin
                            n_flag = (pos_k > eff_size);
                            if (query_k == '0) begin
                                n_state = ST_EMIT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_k    = query_k;
                                n_k     = query_k;
                                n_state = ST_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            n_clr_emit = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (r_op_add) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data + r_delta;
                    if (k_up <= r_size) begin
                        rd_en = 1'b1;
                        rd_k  = k_up;
                        n_k   = k_up;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_acc = r_acc + rd_data;
                    if (k_down != '0) begin
                        rd_en = 1'b1;
                        rd_k  = k_down;
                        n_k   = k_down;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out_word.prefix_sum   = r_acc;
                    n_out_word.out_of_range = r_flag;
                    n_clr_emit              = 1'b0;
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_emit  <= 1'b0;
            r_tree_size <= SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_emit  <= n_clr_emit;
            r_tree_size <= n_tree_size;
            r_out_valid <= n_out_valid;
        end
        r_op_add   <= n_op_add;
        r_k        <= n_k;
        r_size     <= n_size;
        r_delta    <= n_delta;
        r_acc      <= n_acc;
        r_flag     <= n_flag;
        r_out_word <= n_out_word;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/core/fpst_checker.sv =====
// Port-level checker for the Fenwick prefix-sum table and its bind statement.
// Depends on fpst_pkg and on the top level fenwick_prefix_sum_table.
module fpst_port_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fpst_pkg::t_out_word o_out_word
);
    import fpst_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after a word was taken");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready high while the store is being cleared");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result word dropped before it was taken");

    a_out_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_word))
        else $error("result word changed while stalled");

endmodule

bind fenwick_prefix_sum_table fpst_port_props u_fpst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== test/fpst_checker.sv =====
// Checker for the Fenwick prefix-sum table: watches the input, result and size-register
// channels, predicts each result word with its own table model and compares field by field.
// Depends on fpst_pkg.
module fpst_checker #(
    parameter int MAX_POSITIONS = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  fpst_pkg::t_in_word         i_in_word,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  fpst_pkg::t_out_word        i_out_word,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [fpst_pkg::SIZE_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import fpst_pkg::*;

    localparam int AW = $clog2(MAX_POSITIONS);

    logic [DATA_W-1:0] bit_sums [MAX_POSITIONS];
    logic [SIZE_W-1:0] tree_size_reg;
    t_out_word         predicted_words [$];

    function automatic t_out_word apply_operation(input t_in_word w);
        t_out_word         r;
        logic [31:0]       k;
        logic [31:0]       sz;
        logic [31:0]       pos;
        logic [AW-1:0]     idx;
        logic [DATA_W-1:0] acc;
        r   = '0;
        pos = 32'(w.position);
        sz  = (32'(tree_size_reg) > 32'(MAX_POSITIONS)) ? 32'(MAX_POSITIONS)
                                                        : 32'(tree_size_reg);
        case (w.opcode)
            OP_ADD: begin
                if (pos == 32'd0 || pos > sz) begin
                    r.out_of_range = 1'b1;
                end else begin
                    k = pos;
                    while (k != 32'd0 && k <= sz) begin
                        idx           = AW'(k - 32'd1);
                        bit_sums[idx] = bit_sums[idx] + w.delta;
                        k = k + (k & (~k + 32'd1));
                    end
                end
            end
            OP_QUERY: begin
                k = pos;
                if (k > sz) begin
                    k = sz;
                    r.out_of_range = 1'b1;
                end
                acc = '0;
                while (k != 32'd0) begin
                    if (k <= 32'(MAX_POSITIONS)) begin
                        idx = AW'(k - 32'd1);
                        acc = acc + bit_sums[idx];
                    end
                    k = k - (k & (~k + 32'd1));
                end
                r.prefix_sum = acc;
            end
            OP_CLEAR: begin
                foreach (bit_sums[i]) bit_sums[i] = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("[%0t] %s mismatch: predicted %h, observed %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            foreach (bit_sums[i]) bit_sums[i] = '0;
            tree_size_reg = SIZE_RESET;
            predicted_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                tree_size_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    note_mismatch("unpredicted result word, prefix_sum", '0,
                                  i_out_word.prefix_sum);
                end else begin
                    want = predicted_words.pop_front();
                    if (i_out_word.prefix_sum !== want.prefix_sum) begin
                        note_mismatch("prefix_sum", want.prefix_sum, i_out_word.prefix_sum);
                    end
                    if (i_out_word.out_of_range !== want.out_of_range) begin
                        note_mismatch("out_of_range", 32'(want.out_of_range),
                                      32'(i_out_word.out_of_range));
                    end
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_words.push_back(apply_operation(i_in_word));
            end
        end
        o_pending = predicted_words.size();
    end

endmodule

// ===== test/tb_fenwick_prefix_sum_table.sv =====
// Testbench top for the Fenwick prefix-sum table: clock, reset, size-register writes and
// directed plus random operation words with random gaps on both channels.
// Depends on fpst_pkg, fenwick_prefix_sum_table and fpst_checker.
module tb_fenwick_prefix_sum_table;
    timeunit 1ns;
    timeprecision 1ps;
    import fpst_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         MAX_POS   = 4096;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_word          i_in_word   = '0;
    logic              i_out_ready = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [SIZE_W-1:0] i_cfg_data  = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_word         o_out_word;
    logic              o_cfg_ready;

    int       fail_count;
    int       pending;
    int       checked;
    bit       in_idle_en  = 1'b1;
    bit       out_idle_en = 1'b1;
    t_in_word word_queue [$];
    int       n_add, n_query, n_clear, n_unused, n_sizes;

    fenwick_prefix_sum_table #(
        .MAX_POSITIONS(MAX_POS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    fpst_checker #(
        .MAX_POSITIONS(MAX_POS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= !out_idle_en || ($urandom_range(99) >= 34);
    end

    function automatic void push_word(input logic [1:0] op, input logic [POS_W-1:0] pos,
                                      input logic [DATA_W-1:0] d);
        t_in_word w;
        w.opcode   = op;
        w.position = pos;
        w.delta    = d;
        word_queue.push_back(w);
        case (op)
            OP_ADD:   n_add++;
            OP_QUERY: n_query++;
            OP_CLEAR: n_clear++;
            default:  n_unused++;
        endcase
    endfunction

    function automatic void push_random_word(input int eff);
        int                r;
        logic [1:0]        op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] d;
        r  = $urandom_range(99);
        op = (r < 2) ? OP_UNUSED : (r < 4) ? OP_CLEAR : (r < 50) ? OP_ADD : OP_QUERY;
        if ($urandom_range(99) < 85) begin
            pos = POS_W'($urandom_range(eff + 1, 0));
        end else begin
            pos = POS_W'($urandom());
        end
        r = $urandom_range(99);
        if (r < 70) begin
            d = DATA_W'($urandom_range(2000)) - DATA_W'(1000);
        end else if (r < 90) begin
            d = $urandom();
        end else begin
            case ($urandom_range(3))
                0:       d = 32'h7FFF_FFFF;
                1:       d = 32'h8000_0000;
                2:       d = 32'hFFFF_FFFF;
                default: d = 32'h0000_0000;
            endcase
        end
        push_word(op, pos, d);
    endfunction

    task automatic drive_queue();
        while (word_queue.size() != 0) begin
            @(negedge i_clk);
            if (in_idle_en && $urandom_range(99) < 34) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_word  <= word_queue[0];
                do @(posedge i_clk); while (!o_in_ready);
                void'(word_queue.pop_front());
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic set_tree_size(input logic [SIZE_W-1:0] v);
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_sizes++;
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] v, input int count);
        int eff;
        set_tree_size(v);
        eff = (int'(v) > MAX_POS) ? MAX_POS : int'(v);
        repeat (count) push_random_word(eff);
        drive_queue();
    endtask

    initial begin
        #50000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_word(OP_CLEAR, 13'd0, 32'h0);
        push_word(OP_ADD, 13'd1, 32'h7FFF_FFFF);
        push_word(OP_ADD, 13'd4096, 32'h8000_0000);
        push_word(OP_ADD, 13'd0, 32'hFFFF_FFFF);
        push_word(OP_ADD, 13'd4097, 32'h1234_5678);
        push_word(OP_ADD, 13'd8191, 32'hFFFF_FFFF);
        push_word(OP_QUERY, 13'd0, 32'h0);
        push_word(OP_QUERY, 13'd1, 32'h0);
        push_word(OP_QUERY, 13'd4096, 32'h0);
        push_word(OP_QUERY, 13'd4097, 32'h0);
        push_word(OP_QUERY, 13'd8191, 32'hFFFF_FFFF);
        push_word(OP_ADD, 13'd1, 32'h0000_0001);
        push_word(OP_QUERY, 13'd1, 32'h0);
        push_word(OP_ADD, 13'd2048, 32'h5A5A_5A5A);
        push_word(OP_ADD, 13'd4095, 32'hFFFF_FFFF);
        push_word(OP_QUERY, 13'd2048, 32'h0);
        push_word(OP_QUERY, 13'd4095, 32'h0);
        push_word(OP_UNUSED, 13'd8191, 32'hFFFF_FFFF);
        push_word(OP_QUERY, 13'd4096, 32'h0);
        push_word(OP_CLEAR, 13'd8191, 32'hFFFF_FFFF);
        push_word(OP_QUERY, 13'd4096, 32'h0);
        push_word(OP_ADD, 13'd3, 32'h0000_0005);
        push_word(OP_QUERY, 13'd3, 32'h0);
        drive_queue();

        run_phase(13'd4096, 200);
        run_phase(13'd1, 50);
        run_phase(13'd2, 40);
        run_phase(13'd0, 30);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        run_phase(13'd8191, 100);
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        run_phase(13'd100, 100);
        run_phase(SIZE_W'($urandom_range(4094, 3)), 130);
        run_phase(13'd4095, 100);

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("Sent %0d adds, %0d queries, %0d clears and %0d unused-opcode words",
                 n_add, n_query, n_clear, n_unused);
        $display("over %0d size settings; %0d result words checked, %0d mismatches.",
                 n_sizes, checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== fenwick_prefix_sum_table.f =====
rtl/core/fpst_pkg.sv
rtl/core/fpst_ram.sv
rtl/core/fenwick_prefix_sum_table.sv
rtl/core/fpst_checker.sv
test/fpst_checker.sv
test/tb_fenwick_prefix_sum_table.sv
